>>> design/dpf_pkg.sv
`timescale 1ns / 1ps
// dpf_pkg: widths, reset values, codes and stage payload types of the
// Doppler pitch factor pipeline. No dependencies.
package dpf_pkg;

   // field widths
   localparam int COORD_BITS      = 24;
   localparam int PITCH_FRAC_BITS = 14;
   localparam int PITCH_W         = 16;
   localparam int FACTOR_W        = 16;
   localparam int SPEED_W         = 24;
   localparam int AXES            = 3;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOPPLER_FACTOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_OF_SOUND = 1'b1;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;
   localparam logic [SPEED_W-1:0]  SPEED_RESET  = 24'd87808;

   // axis normalisation and square root
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int NORM_W     = 30;
   localparam int SHIFT_W    = 5;
   localparam int SQ_W       = 2 * NORM_W;
   localparam int SQRT_STEPS = 32;
   localparam int ROOT_W     = 2 * SQRT_STEPS - 1;

   // unit axis division
   localparam int LEN_W      = NORM_W + 1;
   localparam int REM_W      = LEN_W + 1;
   localparam int QU_W       = NORM_W + 1;
   localparam int UDIV_STEPS = QU_W;
   localparam int U_W        = QU_W + 1;

   // projection and ratio
   localparam int VP_W   = COORD_BITS + U_W;
   localparam int DOT_W  = VP_W + 2;
   localparam int PM_W   = DOT_W - NORM_W;
   localparam int P_W    = COORD_BITS + 2;
   localparam int C16_W  = SPEED_W + 8;
   localparam int FP_W   = FACTOR_W + P_W;
   localparam int NUM_W  = FP_W + 1;
   localparam int RREM_W = NUM_W + 1;
   localparam int RQ_W   = PITCH_FRAC_BITS + 1;
   localparam int DEN_MIN = 256;

   localparam logic [PITCH_W-1:0] PITCH_ONE = PITCH_W'(1) << PITCH_FRAC_BITS;
   localparam logic [PITCH_W-1:0] PITCH_LO  = PITCH_W'(1) << (PITCH_FRAC_BITS - 1);
   localparam logic [PITCH_W-1:0] PITCH_HI  = PITCH_W'(2) << PITCH_FRAC_BITS;

   // how the final pitch is formed
   typedef enum logic [3:0] {
      SEL_DIV = 4'b0001,
      SEL_ONE = 4'b0010,
      SEL_LO  = 4'b0100,
      SEL_HI  = 4'b1000
   } pitch_sel_type;

   typedef struct packed {
      logic [AXES-1:0][COORD_BITS-1:0] sv;
      logic [AXES-1:0][COORD_BITS-1:0] lv;
   } vel_type;

   typedef struct packed {
      logic [AXES-1:0][NORM_W-1:0] e;
      logic [AXES-1:0]             neg;
      vel_type                     vel;
      logic                        unity;
   } axis_side_type;

   typedef struct packed {
      logic [ROOT_W-1:0] x;
      logic [ROOT_W-1:0] res;
      axis_side_type     side;
   } sqrt_data_type;

   typedef struct packed {
      logic [AXES-1:0][REM_W-1:0] r;
      logic [AXES-1:0][QU_W-1:0]  q;
      logic [LEN_W-1:0]           len;
      logic [AXES-1:0]            neg;
      vel_type                    vel;
      logic                       unity;
   } udiv_data_type;

   typedef struct packed {
      logic [RREM_W-1:0] r;
      logic [RQ_W-1:0]   q;
      logic [NUM_W-1:0]  b;
      pitch_sel_type     sel;
   } rdiv_data_type;

endpackage

>>> design/doppler_pitch_factor.sv
`timescale 1ns / 1ps
// doppler_pitch_factor: top level of the Doppler pitch multiplier pipeline.
// Depends on dpf_pkg, dpf_sqrt_cell, dpf_udiv_cell and dpf_rdiv_cell.
//
// Usage:
//   req_* carries one source/listener pair (positions and velocities, Q16.8)
//   over a valid/ready transfer; rsp_pitch_ratio returns the pitch multiplier
//   in Q2.14, clamped to 0.5..2.0, one result per request, in order.
//   csr_write_en/csr_index/csr_wdata write doppler_factor (index 0) and
//   speed_of_sound (index 1); write them only while idle.
// Stages: from request transfer to rsp_valid the item passes 4 front stages,
//   32 square root cells, 31 unit axis divider cells, 5 projection stages,
//   15 ratio divider cells and the output register, in that order.
// Throughput: one item per cycle unless rsp_ready stalls; each stage is its
//   own register with a local ready, so the cells take a new item each cycle.
// Reset: all stage valids clear, registers return to 1.0 and 343.0.
// Stall: while rsp_ready is low the result holds; earlier stages keep
//   filling up to the empty slots and req_ready falls once all are full.
module doppler_pitch_factor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_src_pos_x,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_src_pos_y,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_src_pos_z,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_src_vel_x,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_src_vel_y,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_src_vel_z,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_lis_pos_x,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_lis_pos_y,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_lis_pos_z,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_lis_vel_x,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_lis_vel_y,
   input  logic signed [dpf_pkg::COORD_BITS-1:0] req_lis_vel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dpf_pkg::PITCH_W-1:0]          rsp_pitch_ratio,
   input  logic                                 csr_write_en,
   input  logic [dpf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dpf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int NA = dpf_pkg::AXES;

   // configuration registers
   logic [dpf_pkg::FACTOR_W-1:0] doppler_factor_ff;
   logic [dpf_pkg::SPEED_W-1:0]  speed_of_sound_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         doppler_factor_ff <= dpf_pkg::FACTOR_RESET;
         speed_of_sound_ff <= dpf_pkg::SPEED_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dpf_pkg::CSR_DOPPLER_FACTOR: begin
               doppler_factor_ff <= csr_wdata[dpf_pkg::FACTOR_W-1:0];
            end
            dpf_pkg::CSR_SPEED_OF_SOUND: begin
               speed_of_sound_ff <= csr_wdata[dpf_pkg::SPEED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage 1: difference vector and magnitudes
   logic [NA-1:0][dpf_pkg::COORD_BITS-1:0] sp, lp;
   dpf_pkg::vel_type                       req_vel;
   logic                                   s1_valid_ff, s1_ready;
   logic [NA-1:0][dpf_pkg::DIFF_W-1:0]     s1_e_ff, s1_e_in;
   logic [NA-1:0]                          s1_neg_ff, s1_neg_in;
   dpf_pkg::vel_type                       s1_vel_ff;
   logic                                   s1_unity_ff;
   logic                                   s2_ready;

   assign sp = {req_src_pos_z, req_src_pos_y, req_src_pos_x};
   assign lp = {req_lis_pos_z, req_lis_pos_y, req_lis_pos_x};
   assign req_vel.sv = {req_src_vel_z, req_src_vel_y, req_src_vel_x};
   assign req_vel.lv = {req_lis_vel_z, req_lis_vel_y, req_lis_vel_x};

   always_comb begin
      logic signed [dpf_pkg::DIFF_W-1:0] diff;
      diff = '0;
      for (int i = 0; i < NA; i++) begin
         diff = dpf_pkg::DIFF_W'($signed(sp[i])) - dpf_pkg::DIFF_W'($signed(lp[i]));
         s1_neg_in[i] = diff[dpf_pkg::DIFF_W-1];
         s1_e_in[i]   = s1_neg_in[i] ? -diff : diff;
      end
   end

   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_e_ff     <= s1_e_in;
         s1_neg_ff   <= s1_neg_in;
         s1_vel_ff   <= req_vel;
         s1_unity_ff <= $signed(doppler_factor_ff) <= 0;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: largest magnitude and normalising shift
   logic                                 s2_valid_ff;
   logic [NA-1:0][dpf_pkg::DIFF_W-1:0]   s2_e_ff;
   logic [NA-1:0]                        s2_neg_ff;
   dpf_pkg::vel_type                     s2_vel_ff;
   logic                                 s2_unity_ff;
   logic [dpf_pkg::SHIFT_W-1:0]          s2_shift_ff, s2_shift_in;
   logic [dpf_pkg::DIFF_W-1:0]           mx;
   logic                                 s3_ready;

   always_comb begin
      logic [dpf_pkg::SHIFT_W-1:0] msb;
      msb = '0;
      mx  = s1_e_ff[0];
      for (int i = 1; i < NA; i++) begin
         if (s1_e_ff[i] > mx) begin
            mx = s1_e_ff[i];
         end
      end
      for (int b = 0; b < dpf_pkg::DIFF_W; b++) begin
         if (mx[b]) begin
            msb = dpf_pkg::SHIFT_W'(b);
         end
      end
      s2_shift_in = dpf_pkg::SHIFT_W'(dpf_pkg::NORM_W - 1) - msb;
   end

   assign s2_ready = !s2_valid_ff || s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_e_ff     <= s1_e_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_vel_ff   <= s1_vel_ff;
         s2_unity_ff <= s1_unity_ff || (mx == '0);
         s2_shift_ff <= s2_shift_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: normalised magnitudes
   logic                    s3_valid_ff;
   dpf_pkg::axis_side_type  s3_side_ff, s3_side_in;
   logic                    s4_ready;

   always_comb begin
      s3_side_in.neg   = s2_neg_ff;
      s3_side_in.vel   = s2_vel_ff;
      s3_side_in.unity = s2_unity_ff;
      for (int i = 0; i < NA; i++) begin
         s3_side_in.e[i] = dpf_pkg::NORM_W'(s2_e_ff[i]) << s2_shift_ff;
      end
   end

   assign s3_ready = !s3_valid_ff || s4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_side_ff <= s3_side_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: squares of the normalised magnitudes
   logic                               s4_valid_ff;
   logic [NA-1:0][dpf_pkg::SQ_W-1:0]   s4_sq_ff, s4_sq_in;
   dpf_pkg::axis_side_type             s4_side_ff;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         s4_sq_in[i] = dpf_pkg::SQ_W'(s3_side_ff.e[i]) * dpf_pkg::SQ_W'(s3_side_ff.e[i]);
      end
   end

   logic [dpf_pkg::SQRT_STEPS:0]       sq_valid, sq_ready;
   dpf_pkg::sqrt_data_type             sq_data [dpf_pkg::SQRT_STEPS+1];

   assign s4_ready = !s4_valid_ff || sq_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s4_ready) begin
         s4_sq_ff   <= s4_sq_in;
         s4_side_ff <= s3_side_ff;
      end
   end

   // ---------------------------------------------------------------
   // square root chain, one result bit per cell
   assign sq_valid[0]     = s4_valid_ff;
   assign sq_data[0].x    = dpf_pkg::ROOT_W'(s4_sq_ff[0]) + dpf_pkg::ROOT_W'(s4_sq_ff[1])
                          + dpf_pkg::ROOT_W'(s4_sq_ff[2]);
   assign sq_data[0].res  = '0;
   assign sq_data[0].side = s4_side_ff;

   logic [dpf_pkg::UDIV_STEPS:0]  ud_valid, ud_ready;
   dpf_pkg::udiv_data_type        ud_data [dpf_pkg::UDIV_STEPS+1];

   for (genvar k = 0; k < dpf_pkg::SQRT_STEPS; k++) begin : g_sqrt
      logic [dpf_pkg::ROOT_W-1:0] bit_k;
      assign bit_k = dpf_pkg::ROOT_W'(1) << (dpf_pkg::ROOT_W - 1 - 2 * k);
      dpf_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_bit  (bit_k),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_data   (sq_data[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_data  (sq_data[k+1])
      );
   end

   assign sq_ready[dpf_pkg::SQRT_STEPS] = ud_ready[0];

   // ---------------------------------------------------------------
   // unit axis divider chain, one quotient bit per cell
   always_comb begin
      ud_data[0].len   = sq_data[dpf_pkg::SQRT_STEPS].res[dpf_pkg::LEN_W-1:0];
      ud_data[0].neg   = sq_data[dpf_pkg::SQRT_STEPS].side.neg;
      ud_data[0].vel   = sq_data[dpf_pkg::SQRT_STEPS].side.vel;
      ud_data[0].unity = sq_data[dpf_pkg::SQRT_STEPS].side.unity;
      for (int i = 0; i < NA; i++) begin
         ud_data[0].r[i] = dpf_pkg::REM_W'(sq_data[dpf_pkg::SQRT_STEPS].side.e[i]);
         ud_data[0].q[i] = '0;
      end
   end
   assign ud_valid[0] = sq_valid[dpf_pkg::SQRT_STEPS];

   for (genvar k = 0; k < dpf_pkg::UDIV_STEPS; k++) begin : g_udiv
      dpf_udiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ud_valid[k]),
         .in_ready  (ud_ready[k]),
         .in_data   (ud_data[k]),
         .out_valid (ud_valid[k+1]),
         .out_ready (ud_ready[k+1]),
         .out_data  (ud_data[k+1])
      );
   end

   // ---------------------------------------------------------------
   // stage d1: velocity times signed unit axis
   logic                               d1_valid_ff, d1_ready, d2_ready;
   logic [NA-1:0][dpf_pkg::VP_W-1:0]   d1_pl_ff, d1_ps_ff, d1_pl_in, d1_ps_in;
   logic                               d1_unity_ff;
   dpf_pkg::udiv_data_type             ud_last;

   assign ud_last = ud_data[dpf_pkg::UDIV_STEPS];

   always_comb begin
      logic signed [dpf_pkg::U_W-1:0]  u;
      logic signed [dpf_pkg::VP_W-1:0] pl, ps;
      u  = '0;
      pl = '0;
      ps = '0;
      for (int i = 0; i < NA; i++) begin
         u  = ud_last.neg[i] ? -$signed({1'b0, ud_last.q[i]}) : $signed({1'b0, ud_last.q[i]});
         pl = $signed(ud_last.vel.lv[i]) * u;
         ps = $signed(ud_last.vel.sv[i]) * u;
         d1_pl_in[i] = pl;
         d1_ps_in[i] = ps;
      end
   end

   assign d1_ready = !d1_valid_ff || d2_ready;
   assign ud_ready[dpf_pkg::UDIV_STEPS] = d1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (d1_ready) begin
         d1_valid_ff <= ud_valid[dpf_pkg::UDIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ud_valid[dpf_pkg::UDIV_STEPS] && d1_ready) begin
         d1_pl_ff    <= d1_pl_in;
         d1_ps_ff    <= d1_ps_in;
         d1_unity_ff <= ud_last.unity;
      end
   end

   // ---------------------------------------------------------------
   // stage d2: dot products
   logic                        d2_valid_ff, d3_ready;
   logic [dpf_pkg::DOT_W-1:0]   d2_dl_ff, d2_ds_ff;
   logic                        d2_unity_ff;

   assign d2_ready = !d2_valid_ff || d3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_valid_ff <= 1'b0;
      end else if (d2_ready) begin
         d2_valid_ff <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d1_valid_ff && d2_ready) begin
         d2_dl_ff <= dpf_pkg::DOT_W'($signed(d1_pl_ff[0])) + dpf_pkg::DOT_W'($signed(d1_pl_ff[1]))
                   + dpf_pkg::DOT_W'($signed(d1_pl_ff[2]));
         d2_ds_ff <= dpf_pkg::DOT_W'($signed(d1_ps_ff[0])) + dpf_pkg::DOT_W'($signed(d1_ps_ff[1]))
                   + dpf_pkg::DOT_W'($signed(d1_ps_ff[2]));
         d2_unity_ff <= d1_unity_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage d3: drop the axis fraction, truncating toward zero
   function automatic logic [dpf_pkg::P_W-1:0] drop_frac(input logic [dpf_pkg::DOT_W-1:0] dot);
      logic                        neg;
      logic [dpf_pkg::DOT_W-1:0]   mag;
      logic [dpf_pkg::PM_W-1:0]    pm;
      logic [dpf_pkg::PM_W-1:0]    p;
      neg = dot[dpf_pkg::DOT_W-1];
      mag = neg ? -dot : dot;
      pm  = mag[dpf_pkg::DOT_W-1:dpf_pkg::NORM_W];
      p   = neg ? -pm : pm;
      return p[dpf_pkg::P_W-1:0];
   endfunction

   logic                      d3_valid_ff, d4_ready;
   logic [dpf_pkg::P_W-1:0]   d3_pl_ff, d3_ps_ff;
   logic                      d3_unity_ff;

   assign d3_ready = !d3_valid_ff || d4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d3_valid_ff <= 1'b0;
      end else if (d3_ready) begin
         d3_valid_ff <= d2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d2_valid_ff && d3_ready) begin
         d3_pl_ff    <= drop_frac(d2_dl_ff);
         d3_ps_ff    <= drop_frac(d2_ds_ff);
         d3_unity_ff <= d2_unity_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage d4: scale projections by the Doppler factor
   logic                       d4_valid_ff, d5_ready;
   logic signed [dpf_pkg::FP_W-1:0] d4_fl_ff, d4_fs_ff, d4_fl_in, d4_fs_in;
   logic                       d4_unity_ff;

   always_comb begin
      d4_fl_in = $signed(doppler_factor_ff) * $signed(d3_pl_ff);
      d4_fs_in = $signed(doppler_factor_ff) * $signed(d3_ps_ff);
   end

   assign d4_ready = !d4_valid_ff || d5_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d4_valid_ff <= 1'b0;
      end else if (d4_ready) begin
         d4_valid_ff <= d3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d3_valid_ff && d4_ready) begin
         d4_fl_ff    <= d4_fl_in;
         d4_fs_ff    <= d4_fs_in;
         d4_unity_ff <= d3_unity_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage d5: numerator and denominator
   logic                       d5_valid_ff;
   logic [dpf_pkg::NUM_W-1:0]  d5_num_ff, d5_den_ff;
   logic                       d5_unity_ff;
   logic [dpf_pkg::C16_W-1:0]  c16;
   logic [dpf_pkg::RQ_W:0]     rd_valid, rd_ready;
   dpf_pkg::rdiv_data_type     rd_data [dpf_pkg::RQ_W+1];

   assign c16      = {speed_of_sound_ff, 8'd0};
   assign d5_ready = !d5_valid_ff || rd_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         d5_valid_ff <= 1'b0;
      end else if (d5_ready) begin
         d5_valid_ff <= d4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d4_valid_ff && d5_ready) begin
         d5_num_ff   <= dpf_pkg::NUM_W'(c16) + dpf_pkg::NUM_W'(d4_fl_ff);
         d5_den_ff   <= dpf_pkg::NUM_W'(c16) + dpf_pkg::NUM_W'(d4_fs_ff);
         d5_unity_ff <= d4_unity_ff;
      end
   end

   // ---------------------------------------------------------------
   // ratio divider set-up and special cases
   always_comb begin
      logic                       num_neg, den_neg;
      logic [dpf_pkg::NUM_W-1:0]  a, b;
      num_neg = d5_num_ff[dpf_pkg::NUM_W-1];
      den_neg = d5_den_ff[dpf_pkg::NUM_W-1];
      a = num_neg ? -d5_num_ff : d5_num_ff;
      b = den_neg ? -d5_den_ff : d5_den_ff;
      rd_data[0].r = {1'b0, a};
      rd_data[0].q = '0;
      rd_data[0].b = b;
      if (d5_unity_ff || (b < dpf_pkg::NUM_W'(dpf_pkg::DEN_MIN))) begin
         rd_data[0].sel = dpf_pkg::SEL_ONE;
      end else if ((d5_num_ff == '0) || (num_neg != den_neg)) begin
         rd_data[0].sel = dpf_pkg::SEL_LO;
      end else if ({1'b0, a} >= {b, 1'b0}) begin
         rd_data[0].sel = dpf_pkg::SEL_HI;
      end else begin
         rd_data[0].sel = dpf_pkg::SEL_DIV;
      end
   end
   assign rd_valid[0] = d5_valid_ff;

   for (genvar k = 0; k < dpf_pkg::RQ_W; k++) begin : g_rdiv
      dpf_rdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rd_valid[k]),
         .in_ready  (rd_ready[k]),
         .in_data   (rd_data[k]),
         .out_valid (rd_valid[k+1]),
         .out_ready (rd_ready[k+1]),
         .out_data  (rd_data[k+1])
      );
   end

   // ---------------------------------------------------------------
   // output register: final pitch selection and low clamp
   logic                          rsp_valid_ff, out_ready;
   logic [dpf_pkg::PITCH_W-1:0]   rsp_pitch_ff, rsp_pitch_in;
   dpf_pkg::rdiv_data_type        rd_last;

   assign rd_last = rd_data[dpf_pkg::RQ_W];

   always_comb begin
      case (rd_last.sel)
         dpf_pkg::SEL_ONE: rsp_pitch_in = dpf_pkg::PITCH_ONE;
         dpf_pkg::SEL_LO:  rsp_pitch_in = dpf_pkg::PITCH_LO;
         dpf_pkg::SEL_HI:  rsp_pitch_in = dpf_pkg::PITCH_HI;
         dpf_pkg::SEL_DIV: begin
            if (dpf_pkg::PITCH_W'(rd_last.q) < dpf_pkg::PITCH_LO) begin
               rsp_pitch_in = dpf_pkg::PITCH_LO;
            end else begin
               rsp_pitch_in = dpf_pkg::PITCH_W'(rd_last.q);
            end
         end
         default: rsp_pitch_in = dpf_pkg::PITCH_ONE;
      endcase
   end

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign rd_ready[dpf_pkg::RQ_W] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rd_valid[dpf_pkg::RQ_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid[dpf_pkg::RQ_W] && out_ready) begin
         rsp_pitch_ff <= rsp_pitch_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_ratio = rsp_pitch_ff;

   // ---------------------------------------------------------------
   // checks
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_ratio >= dpf_pkg::PITCH_LO)
                 && (rsp_pitch_ratio <= dpf_pkg::PITCH_HI))
      else $error("pitch ratio outside 0.5..2.0");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_factor_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == dpf_pkg::CSR_DOPPLER_FACTOR)
      |=> doppler_factor_ff == $past(csr_wdata[dpf_pkg::FACTOR_W-1:0]))
      else $error("doppler factor write lost");

endmodule

>>> design/dpf_sqrt_cell.sv
`timescale 1ns / 1ps
// dpf_sqrt_cell: one registered step of the integer square root.
// Depends on dpf_pkg.
module dpf_sqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dpf_pkg::ROOT_W-1:0]  step_bit,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  dpf_pkg::sqrt_data_type      in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dpf_pkg::sqrt_data_type      out_data
);

   logic                         valid_ff;
   dpf_pkg::sqrt_data_type       data_ff;
   dpf_pkg::sqrt_data_type       data_in;
   logic [dpf_pkg::ROOT_W-1:0]   trial;
   logic                         take;

   // restoring root step for this bit position
   always_comb begin
      trial   = in_data.res + step_bit;
      take    = in_data.x >= trial;
      data_in = in_data;
      data_in.res = in_data.res >> 1;
      if (take) begin
         data_in.x   = in_data.x - trial;
         data_in.res = (in_data.res >> 1) + step_bit;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/dpf_udiv_cell.sv
`timescale 1ns / 1ps
// dpf_udiv_cell: one registered quotient bit for all three unit axis lanes.
// Depends on dpf_pkg.
module dpf_udiv_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  dpf_pkg::udiv_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dpf_pkg::udiv_data_type  out_data
);

   logic                       valid_ff;
   dpf_pkg::udiv_data_type     data_ff;
   dpf_pkg::udiv_data_type     data_in;
   logic [dpf_pkg::REM_W-1:0]  len_ext;
   logic [dpf_pkg::REM_W-1:0]  rem;
   logic                       ge;

   // compare, subtract, then double the remainder
   always_comb begin
      data_in = in_data;
      len_ext = dpf_pkg::REM_W'(in_data.len);
      rem     = '0;
      ge      = 1'b0;
      for (int i = 0; i < dpf_pkg::AXES; i++) begin
         ge  = in_data.r[i] >= len_ext;
         rem = ge ? in_data.r[i] - len_ext : in_data.r[i];
         data_in.r[i] = {rem[dpf_pkg::REM_W-2:0], 1'b0};
         data_in.q[i] = {in_data.q[i][dpf_pkg::QU_W-2:0], ge};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/dpf_rdiv_cell.sv
`timescale 1ns / 1ps
// dpf_rdiv_cell: one registered quotient bit of the pitch ratio division.
// Depends on dpf_pkg.
module dpf_rdiv_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  dpf_pkg::rdiv_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dpf_pkg::rdiv_data_type  out_data
);

   logic                        valid_ff;
   dpf_pkg::rdiv_data_type      data_ff;
   dpf_pkg::rdiv_data_type      data_in;
   logic [dpf_pkg::RREM_W-1:0]  b_ext;
   logic [dpf_pkg::RREM_W-1:0]  rem;
   logic                        ge;

   // compare, subtract, then double the remainder
   always_comb begin
      data_in = in_data;
      b_ext   = dpf_pkg::RREM_W'(in_data.b);
      ge      = in_data.r >= b_ext;
      rem     = ge ? in_data.r - b_ext : in_data.r;
      data_in.r = {rem[dpf_pkg::RREM_W-2:0], 1'b0};
      data_in.q = {in_data.q[dpf_pkg::RQ_W-2:0], ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
